// ===== rtl/core/mkpt_pkg.sv =====
// Package with the shared types, codes and defaults of the MRU keyed profile table.
`timescale 1ns / 1ps

package mkpt_pkg;

  localparam int MAX_ENTRIES_DEF = 8;
  localparam int KEY_W           = 64;
  localparam int VALUE_W         = 64;
  localparam int COUNT_W         = 16;
  localparam int USED_W          = 4;
  localparam int OP_W            = 2;

  localparam logic [OP_W-1:0] OP_UPSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] found_count;
    logic [USED_W-1:0]  entries_used;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

// ===== rtl/core/mkpt_stream_if.sv =====
// Valid/ready stream interface that carries one payload item per transfer.
`timescale 1ns / 1ps

interface mkpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/mru_keyed_profile_table_top.sv =====
// Top level of the MRU keyed profile table: sequencer, shared key comparator and entry store.
`timescale 1ns / 1ps

// The block keeps up to MAX_ENTRIES entries of a 64-bit key, a 64-bit value and a
// 16-bit success count, ordered from most to least recently used, and takes one
// request per transfer on req (upsert, mark success or find), giving exactly one
// response per request on rsp. A request is accepted only while the sequencer is
// idle. One 64-bit key comparator then walks the valid entries from the front, one
// entry per cycle, and stops at the first match or after the last valid entry; a
// zero key, the unused operation code or an empty table skips the walk. A final
// update state moves a hit entry to the front on upsert or mark (or inserts a new
// one on an upsert miss) and loads the response register; the next request may be
// taken once the response is offered. The response register lets a new request be
// accepted and walked while the previous response still waits; the update state
// holds until that register is free. The table is empty after reset: the valid
// count is cleared and entries past it are never read, so no clearing pass is
// needed.
module mru_keyed_profile_table_top #(
  parameter int MAX_ENTRIES = mkpt_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mkpt_stream_if.sink   req,
  mkpt_stream_if.source rsp
);
  import mkpt_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

  // Entry store; positions 0 .. count-1 hold valid entries, front is most recent.
  logic [KEY_W-1:0]   keys [MAX_ENTRIES];
  logic [VALUE_W-1:0] vals [MAX_ENTRIES];
  logic [COUNT_W-1:0] cnts [MAX_ENTRIES];
  logic [CNT_W-1:0]   count;

  state_t state, state_next;

  // Captured request.
  logic [OP_W-1:0]    op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;

  // Walk position and match capture.
  logic [IDX_W-1:0]   idx;
  logic               hit;
  logic [IDX_W-1:0]   pos;
  logic [VALUE_W-1:0] hit_value;
  logic [COUNT_W-1:0] hit_count;

  // Response register.
  logic rsp_valid;
  rsp_t rsp_data;

  // Sequencer controls.
  logic accept;
  logic scan_skip, scan_last, key_match;
  logic scan_step, scan_capture;
  logic out_free, fire;

  // Update datapath.
  logic               do_insert, do_move;
  logic [IDX_W-1:0]   move_pos;
  logic [VALUE_W-1:0] front_value;
  logic [COUNT_W-1:0] front_count;
  logic [CNT_W-1:0]   count_next;
  logic               ok_next;
  logic [31:0]        used_ext;

  assign accept    = req.valid && req.ready;
  assign key_match = (keys[idx] == key_r);
  assign scan_skip = (key_r == '0) || (op_r == OP_NONE) || (count == '0);
  assign scan_last = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign out_free  = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    req.ready    = 1'b0;
    scan_step    = 1'b0;
    scan_capture = 1'b0;
    fire         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (scan_skip) begin
          state_next = ST_UPDATE;
        end else if (key_match) begin
          scan_capture = 1'b1;
          state_next   = ST_UPDATE;
        end else if (scan_last) begin
          state_next = ST_UPDATE;
        end else begin
          scan_step = 1'b1;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          fire       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Request capture and walk bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
      idx <= '0;
    end else if (accept) begin
      hit <= 1'b0;
      idx <= '0;
    end else begin
      if (scan_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (scan_capture) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= req.data.operation;
      key_r   <= req.data.key;
      value_r <= req.data.value;
    end
    if (scan_capture) begin
      pos       <= idx;
      hit_value <= vals[idx];
      hit_count <= cnts[idx];
    end
  end

  // An upsert miss inserts at the front and pushes everything down; when the table
  // is full the last entry falls off. An upsert or mark hit rotates positions 0 .. pos by one.
  always_comb begin
    do_insert = (op_r == OP_UPSERT) && (key_r != '0) && !hit;
    do_move   = hit && ((op_r == OP_UPSERT) || (op_r == OP_MARK));

    if (hit) begin
      move_pos = pos;
    end else if (count == CNT_FULL) begin
      move_pos = IDX_LAST;
    end else begin
      move_pos = IDX_W'(count);
    end

    if (do_insert) begin
      front_value = value_r;
      front_count = '0;
    end else begin
      front_value = ((op_r == OP_UPSERT) && (value_r != '0)) ? value_r : hit_value;
      if ((op_r == OP_MARK) && (hit_count != COUNT_MAX)) begin
        front_count = hit_count + COUNT_W'(1);
      end else begin
        front_count = hit_count;
      end
    end

    count_next = (do_insert && (count != CNT_FULL)) ? count + CNT_W'(1) : count;
    ok_next    = do_insert || hit;
    used_ext   = 32'(count_next);
  end

  always_ff @(posedge clk) begin
    if (fire && (do_insert || do_move)) begin
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (IDX_W'(i) <= move_pos) begin
          keys[i] <= keys[i-1];
          vals[i] <= vals[i-1];
          cnts[i] <= cnts[i-1];
        end
      end
      keys[0] <= key_r;
      vals[0] <= front_value;
      cnts[0] <= front_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Response register; a new response is loaded only once the previous one has
  // been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data.ok           <= ok_next;
      rsp_data.found_value  <= ok_next ? front_value : '0;
      rsp_data.found_count  <= ok_next ? front_count : '0;
      rsp_data.entries_used <= used_ext[USED_W-1:0];
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // The valid count never runs past the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("valid entry count exceeds table size");

  // The walk never looks at a position past the valid entries.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) && (count != '0) |-> (CNT_W'(idx) < count))
    else $error("walk index past valid entries");

  // A failed request reports a zero value and count.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_data.ok |-> (rsp_data.found_value == '0) &&
                                  (rsp_data.found_count == '0))
    else $error("failed response carries nonzero data");

  // An accepted request always starts a walk in the next cycle.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (idx == '0) && !hit)
    else $error("accepted request did not start a walk");

endmodule
